// ===== rtl/core/eeg_pkg.sv =====
// Package for the extended Euclidean gcd unit.
// Holds field widths, request and response payload types, and the controller/datapath links.
// Used by every module under rtl/core; depends on nothing.
package eeg_pkg;

    // Operand and coefficient widths are fixed by the payload fields.
    localparam int OPERAND_W     = 31;
    localparam int COEF_W        = 32;
    localparam int WIDTH_DEFAULT = 32;

    // Request payload: two unordered operands.
    typedef struct packed {
        logic [OPERAND_W-1:0] first_value;
        logic [OPERAND_W-1:0] second_value;
    } t_eeg_req;

    // Response payload: Bezout coefficients and the gcd.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_larger;
        logic signed [COEF_W-1:0] coef_smaller;
        logic [OPERAND_W-1:0]     divisor;
    } t_eeg_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic upd;
        logic out_load;
    } t_eeg_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r1_zero;
    } t_eeg_sts;

endpackage

// ===== rtl/core/extended_euclid_gcd_unit.sv =====
// Extended Euclidean gcd unit: top level joining controller and datapath.
// Depends on eeg_pkg, eeg_ctrl and eeg_dp.
//
// Usage: a request on i_req (two unordered 31-bit operands) is taken at a
// clock edge where i_req_valid is high and o_req_stall is low. The response on
// o_rsp carries the gcd and the Bezout coefficients of the larger and smaller
// operand, and is taken where o_rsp_valid is high and i_rsp_stall is low.
// One request is worked on at a time; o_req_stall is high from acceptance
// until the response has been written to the output register.
// Each Euclid step runs the bit-serial divider, the coefficient multiplies,
// the update and the loop test; for 31-bit operands a request needs at most
// 46 steps. The loop stops after 2 * WIDTH steps at the latest.
// The output register frees the request side: a new request is accepted while
// a finished response waits under i_rsp_stall, but its own result is held back
// until that response has been taken. Reset clears the response valid flag and
// returns the controller to idle; no clearing pass is needed.
module extended_euclid_gcd_unit #(
    parameter int WIDTH = eeg_pkg::WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  eeg_pkg::t_eeg_req i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output eeg_pkg::t_eeg_rsp o_rsp
);
    import eeg_pkg::*;

    t_eeg_cmd w_cmd;
    t_eeg_sts w_sts;

    // Sequencer and handshakes.
    eeg_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and payload registers.
    eeg_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (w_cmd),
        .i_req (i_req),
        .o_sts (w_sts),
        .o_rsp (o_rsp)
    );

endmodule

// ===== rtl/core/eeg_dp.sv =====
// Datapath of the extended Euclidean gcd unit.
// Holds the remainder pair, the coefficient pairs, a bit-serial divider and the response register.
// Depends on eeg_pkg; driven by eeg_ctrl through t_eeg_cmd.
module eeg_dp (
    input  logic              i_clk,
    input  eeg_pkg::t_eeg_cmd i_cmd,
    input  eeg_pkg::t_eeg_req i_req,
    output eeg_pkg::t_eeg_sts o_sts,
    output eeg_pkg::t_eeg_rsp o_rsp
);
    import eeg_pkg::*;

    logic [OPERAND_W-1:0] r_r0;
    logic [OPERAND_W-1:0] r_r1;
    logic [COEF_W-1:0]    r_x0;
    logic [COEF_W-1:0]    r_x1;
    logic [COEF_W-1:0]    r_y0;
    logic [COEF_W-1:0]    r_y1;
    logic [OPERAND_W-1:0] r_rem;
    logic [OPERAND_W-1:0] r_quo;
    logic [COEF_W-1:0]    r_px;
    logic [COEF_W-1:0]    r_py;
    t_eeg_rsp             r_rsp;

    logic [OPERAND_W:0]   w_trial;
    logic                 w_ge;
    logic [COEF_W-1:0]    w_quo_ext;

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign w_trial   = {r_rem, r_quo[OPERAND_W-1]} - {1'b0, r_r1};
    assign w_ge      = ~w_trial[OPERAND_W];
    assign w_quo_ext = {{(COEF_W-OPERAND_W){1'b0}}, r_quo};

    // Operand registers and the Euclid step update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_req.first_value >= i_req.second_value) begin
                r_r0 <= i_req.first_value;
                r_r1 <= i_req.second_value;
            end else begin
                r_r0 <= i_req.second_value;
                r_r1 <= i_req.first_value;
            end
            r_x0 <= COEF_W'(1);
            r_x1 <= '0;
            r_y0 <= '0;
            r_y1 <= COEF_W'(1);
        end else if (i_cmd.upd) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_x0 <= r_x1;
            r_x1 <= r_x0 - r_px;
            r_y0 <= r_y1;
            r_y1 <= r_y0 - r_py;
        end
    end

    // Bit-serial divider: the quotient register starts with the dividend.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_r0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial[OPERAND_W-1:0] : {r_rem[OPERAND_W-2:0], r_quo[OPERAND_W-1]};
            r_quo <= {r_quo[OPERAND_W-2:0], w_ge};
        end
    end

    // Products of the quotient and the newer coefficients, kept modulo two to the COEF_W.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= w_quo_ext * r_x1;
            r_py <= w_quo_ext * r_y1;
        end
    end

    // Response register, loaded when the loop has finished.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.coef_larger  <= r_x0;
            r_rsp.coef_smaller <= r_y0;
            r_rsp.divisor      <= r_r0;
        end
    end

    assign o_sts.r1_zero = (r_r1 == '0);
    assign o_rsp         = r_rsp;

endmodule

// ===== rtl/core/eeg_ctrl.sv =====
// Controller of the extended Euclidean gcd unit.
// Sequences load, division, multiply and update phases and owns both handshakes.
// Depends on eeg_pkg; drives eeg_dp through t_eeg_cmd.
module eeg_ctrl #(
    parameter int WIDTH = eeg_pkg::WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    input  eeg_pkg::t_eeg_sts i_sts,
    output eeg_pkg::t_eeg_cmd o_cmd
);
    import eeg_pkg::*;

    localparam int STEP_LIMIT = 2 * WIDTH;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
    localparam int BIT_W      = $clog2(OPERAND_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_UPD
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [BIT_W-1:0]  r_bit;
    logic              r_rsp_valid;
    logic              w_done;
    logic              w_rsp_free;

    assign w_done     = i_sts.r1_zero || (r_step == STEP_W'(STEP_LIMIT));
    assign w_rsp_free = !r_rsp_valid || !i_rsp_stall;

    // Datapath commands decoded from the current state.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load = i_req_valid;
            S_CHECK: begin
                o_cmd.out_load = w_done && w_rsp_free;
                o_cmd.div_init = !w_done;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_UPD:   o_cmd.upd = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    // State, counters and the response valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_bit       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_step  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_done) begin
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end else if (w_rsp_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(OPERAND_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_UPD;
                S_UPD: begin
                    r_step  <= r_step + STEP_W'(1);
                    r_state <= S_CHECK;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

// ===== rtl/core/eeg_chk.sv =====
// Port-level checker for the extended Euclidean gcd unit, bound to the top level.
// Depends on eeg_pkg and sees only the ports of extended_euclid_gcd_unit.
module eeg_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_stall,
    input logic              o_rsp_valid,
    input logic              i_rsp_stall,
    input eeg_pkg::t_eeg_rsp o_rsp
);
    import eeg_pkg::*;

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // An accepted request blocks the next one while it is worked on.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request side not stalled after acceptance");

    // A new response only appears at the end of a busy period.
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(o_req_stall))
        else $error("response appeared without a request in progress");

    // A zero gcd only arises from two zero operands, giving coefficients one and zero.
    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.divisor == '0) |->
            (o_rsp.coef_larger == COEF_W'(1)) && (o_rsp.coef_smaller == '0))
        else $error("zero gcd with wrong coefficients");

endmodule

bind extended_euclid_gcd_unit eeg_chk u_eeg_chk (.*);

// ===== tb/extended_euclid_gcd_unit_tb.sv =====
// Self-checking testbench for the extended Euclidean gcd unit.
// Drives requests through the valid/stall handshake and checks each response against
// an in-bench Bezout predictor; depends only on eeg_pkg and extended_euclid_gcd_unit.
module extended_euclid_gcd_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import eeg_pkg::*;

    localparam int          GCD_WIDTH      = WIDTH_DEFAULT;
    localparam int          RANDOM_ITEMS   = 350;
    localparam int          LONG_HOLD      = 3000;
    localparam int          TAIL_CYCLES    = 1600;
    localparam int          WATCHDOG_LIMIT = 12000;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [30:0] OPERAND_MAX    = 31'h7FFF_FFFF;

    // Holds the predicted responses in request order and compares them with the outputs.
    class gcd_scoreboard;
        int unsigned step_bound;
        t_eeg_rsp    bezout_q[$];
        int unsigned mismatches;

        function new(int unsigned width);
            step_bound = 2 * width;
            mismatches = 0;
        endfunction

        // Quotient-based extended Euclid on (larger, smaller), capped at the step bound.
        function t_eeg_rsp predict_bezout(t_eeg_req req);
            longint      r0, r1, x0, x1, y0, y1, quo, nxt;
            int unsigned step;
            t_eeg_rsp    rsp;
            r0 = longint'(req.first_value);
            r1 = longint'(req.second_value);
            if (r1 > r0) begin
                nxt = r0;
                r0  = r1;
                r1  = nxt;
            end
            x0 = 1;
            x1 = 0;
            y0 = 0;
            y1 = 1;
            step = 0;
            while (step < step_bound && r1 != 0) begin
                quo = r0 / r1;
                nxt = r0 - quo * r1;
                r0  = r1;
                r1  = nxt;
                nxt = x0 - quo * x1;
                x0  = x1;
                x1  = nxt;
                nxt = y0 - quo * y1;
                y0  = y1;
                y1  = nxt;
                step++;
            end
            rsp.coef_larger  = x0[COEF_W-1:0];
            rsp.coef_smaller = y0[COEF_W-1:0];
            rsp.divisor      = r0[OPERAND_W-1:0];
            return rsp;
        endfunction

        function void note_request(t_eeg_req req);
            bezout_q.push_back(predict_bezout(req));
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endfunction

        function void check_response(t_eeg_rsp got);
            t_eeg_rsp want;
            if (bezout_q.size() == 0) begin
                report($sformatf("unexpected response x=%0d y=%0d d=%0d",
                                 got.coef_larger, got.coef_smaller, got.divisor));
                return;
            end
            want = bezout_q.pop_front();
            if (got.coef_larger !== want.coef_larger || got.coef_smaller !== want.coef_smaller
                    || got.divisor !== want.divisor) begin
                report($sformatf("expected x=%0d y=%0d d=%0d, got x=%0d y=%0d d=%0d",
                                 want.coef_larger, want.coef_smaller, want.divisor,
                                 got.coef_larger, got.coef_smaller, got.divisor));
            end
        endfunction

        function int unsigned pending();
            return bezout_q.size();
        endfunction
    endclass

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_req_valid = 1'b0;
    t_eeg_req i_req       = '0;
    logic     i_rsp_stall = 1'b0;
    logic     o_req_stall;
    logic     o_rsp_valid;
    t_eeg_rsp o_rsp;

    // Set by the stimulus to steer the response side.
    bit steady_tail  = 1'b0;
    bit rsp_hold_req = 1'b0;

    gcd_scoreboard sb = new(GCD_WIDTH);

    extended_euclid_gcd_unit #(
        .WIDTH(GCD_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    // 4 ns clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Offers one request, waits for it to be taken, then sometimes leaves a gap.
    task automatic push_operands(input logic [OPERAND_W-1:0] a,
                                 input logic [OPERAND_W-1:0] b);
        t_eeg_req req;
        req.first_value  = a;
        req.second_value = b;
        i_req_valid <= 1'b1;
        i_req       <= req;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        sb.note_request(req);
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Withdraws the request side until every outstanding response has been checked.
    task automatic wait_for_drain();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Random operand pairs: full-range most often, with narrow, zero, equal, multiple
    // and consecutive Fibonacci pairs mixed in.
    function automatic t_eeg_req random_request();
        t_eeg_req             req;
        logic [OPERAND_W-1:0] a, b, t;
        longint               fa, fb, fn;
        int unsigned          kind, span, idx;
        kind = $urandom_range(0, 9);
        a = OPERAND_W'($urandom());
        b = OPERAND_W'($urandom());
        case (kind)
            4: begin
                span = $urandom_range(1, OPERAND_W);
                a = a >> (OPERAND_W - span);
                b = b >> (OPERAND_W - span);
            end
            5: begin
                b = '0;
            end
            6: begin
                b = a;
            end
            7: begin
                b = OPERAND_W'($urandom_range(1, 1 << 20));
                a = OPERAND_W'(b * $urandom_range(2, 1000));
            end
            8: begin
                idx = $urandom_range(2, 46);
                fa = 1;
                fb = 0;
                for (int k = 1; k < idx; k++) begin
                    fn = fa + fb;
                    fb = fa;
                    fa = fn;
                end
                a = fa[OPERAND_W-1:0];
                b = fb[OPERAND_W-1:0];
            end
            9: begin
                a = OPERAND_W'($urandom_range(0, 255));
                b = OPERAND_W'($urandom_range(0, 255));
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            t = a;
            a = b;
            b = t;
        end
        req.first_value  = a;
        req.second_value = b;
        return req;
    endfunction

    // Response side: checks every taken response and stalls in random bursts.
    initial begin : response_side
        int unsigned stall_left;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_rsp_valid && !i_rsp_stall) begin
                sb.check_response(o_rsp);
            end
            if (rsp_hold_req) begin
                stall_left   = LONG_HOLD;
                rsp_hold_req = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
            end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            i_rsp_stall <= (stall_left != 0);
        end
    end

    // Ends the run if neither channel completes a handshake for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, directed corner cases, then random requests with the pressure phases.
    initial begin : stimulus
        t_eeg_req req;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero operands, equal operands, extremes and the longest Fibonacci chain.
        push_operands(31'd0, 31'd0);
        push_operands(31'd0, 31'd5);
        push_operands(31'd5, 31'd0);
        push_operands(31'd0, OPERAND_MAX);
        push_operands(OPERAND_MAX, OPERAND_MAX);
        push_operands(31'd7, 31'd7);
        push_operands(31'd1, 31'd1);
        push_operands(31'd1, 31'd0);
        push_operands(OPERAND_MAX, 31'd1);
        push_operands(31'd1, OPERAND_MAX);
        push_operands(OPERAND_MAX, OPERAND_MAX - 31'd1);
        push_operands(31'd1836311903, 31'd1134903170);
        push_operands(31'd1134903170, 31'd1836311903);
        push_operands(31'h4000_0000, 31'h2000_0000);
        push_operands(31'd12, 31'd18);
        push_operands(31'd240, 31'd46);
        push_operands(31'h5555_5555, 31'h2AAA_AAAA);
        push_operands(31'h4000_0000, 31'h3FFF_FFFF);
        push_operands(31'd1234567890, 31'd987654321);
        push_operands(OPERAND_MAX, 31'h4000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // The response side holds off for a long time while requests keep coming.
            if (n == 100) begin
                rsp_hold_req = 1'b1;
            end
            // The request side pauses until everything outstanding has come back.
            if (n == 180) begin
                wait_for_drain();
            end
            if (n == RANDOM_ITEMS - 60) begin
                steady_tail = 1'b1;
            end
            req = random_request();
            push_operands(req.first_value, req.second_value);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d responses never arrived", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
